[src/weighted_variance_cell_bank_top_macros.svh]
// Assertion macros for the weighted variance cell bank.
`ifndef WEIGHTED_VARIANCE_CELL_BANK_TOP_MACROS_SVH
`define WEIGHTED_VARIANCE_CELL_BANK_TOP_MACROS_SVH

// Same-cycle implication.
`define WVCB_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("wvcb: check failed");

// Implication across the full item latency, up to the edge that takes the result.
`define WVCB_ASSERT_LAT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (a) |-> ##(wvcb_pkg::LATENCY + 1) (c)) else $error("wvcb: latency check failed");

`endif

[src/wvcb_pkg.sv]
// Types, constants and helpers for the weighted variance cell bank.
package wvcb_pkg;

    localparam int CELL_COUNT = 4096;
    localparam int CELL_AW    = $clog2(CELL_COUNT);
    localparam int IDX_W      = 12;
    localparam int VAL_W      = 17;
    localparam int WT_W       = 32;
    localparam int SP_W       = 40;
    localparam int PROD1_W    = 2 * VAL_W;
    localparam int PROD2_W    = PROD1_W + VAL_W;
    localparam int INC_W      = PROD2_W - 16;
    localparam int Q_W        = 17;
    localparam int DIV_STAGES = Q_W;
    localparam int LATENCY    = 2 * DIV_STAGES + 4;

    localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [1:0] FUNC_ACC      = 2'd0;
    localparam logic [1:0] FUNC_READ     = 2'd1;
    localparam logic [1:0] FUNC_CLEAR    = 2'd2;
    localparam logic [1:0] FUNC_READ_ALT = 2'd3;

    typedef struct packed {
        logic [VAL_W-1:0] m;
        logic [WT_W-1:0]  wt;
        logic [SP_W-1:0]  s;
    } t_entry;

    typedef struct packed {
        logic               valid;
        logic [1:0]         func;
        logic [CELL_AW-1:0] addr;
        logic [VAL_W-1:0]   v;
        logic [VAL_W-1:0]   w;
    } t_stage_a;

    typedef struct packed {
        logic               valid;
        logic               upd;
        logic               dir;
        logic [CELL_AW-1:0] addr;
        logic [VAL_W-1:0]   v;
        logic [VAL_W-1:0]   m;
        logic [WT_W-1:0]    wt;
        logic [SP_W-1:0]    s;
        logic [VAL_W-1:0]   d_old;
        logic [PROD1_W-1:0] p;
    } t_stage_b;

    typedef struct packed {
        logic               valid;
        logic               upd;
        logic [CELL_AW-1:0] addr;
        logic [VAL_W-1:0]   m;
        logic [WT_W-1:0]    wt;
        logic [SP_W-1:0]    s;
        logic [PROD2_W-1:0] prod;
    } t_stage_e;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] m;
        logic [WT_W-1:0]  wt;
        logic [SP_W-1:0]  s;
    } t_stage_f;

    typedef struct packed {
        logic             valid;
        logic             empty;
        logic             ovf;
        logic [VAL_W-1:0] m;
    } t_stage_g;

    // One restoring step: returns {quotient bit, new remainder}.
    function automatic logic [WT_W:0] div_step(input logic [WT_W-1:0] rem,
                                               input logic [WT_W-1:0] dv,
                                               input logic            b);
        logic [WT_W:0] t;
        logic [WT_W:0] d;
        logic [WT_W:0] r;
        t = {rem, b};
        d = {1'b0, dv};
        if (t >= d) begin
            r = t - d;
            return {1'b1, r[WT_W-1:0]};
        end
        return {1'b0, t[WT_W-1:0]};
    endfunction

endpackage

[src/wvcb_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module wvcb_div (
    input  logic                      i_clk,
    input  logic [wvcb_pkg::WT_W-1:0] i_rem,
    input  logic [wvcb_pkg::Q_W-1:0]  i_low,
    input  logic [wvcb_pkg::WT_W-1:0] i_div,
    output logic [wvcb_pkg::Q_W-1:0]  o_quot
);

    logic [wvcb_pkg::WT_W-1:0] r_rem  [wvcb_pkg::DIV_STAGES];
    logic [wvcb_pkg::Q_W-1:0]  r_low  [wvcb_pkg::DIV_STAGES];
    logic [wvcb_pkg::Q_W-1:0]  r_quot [wvcb_pkg::DIV_STAGES];
    logic [wvcb_pkg::WT_W-1:0] r_dv   [wvcb_pkg::DIV_STAGES];

    logic [wvcb_pkg::WT_W:0]   n_st   [wvcb_pkg::DIV_STAGES];

    always_comb begin
        n_st[0] = wvcb_pkg::div_step(i_rem, i_div, i_low[wvcb_pkg::Q_W-1]);
        for (int s = 1; s < wvcb_pkg::DIV_STAGES; s++) begin
            n_st[s] = wvcb_pkg::div_step(r_rem[s-1], r_dv[s-1],
                                         r_low[s-1][wvcb_pkg::Q_W-1-s]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_st[0][wvcb_pkg::WT_W-1:0];
        r_low[0]  <= i_low;
        r_dv[0]   <= i_div;
        r_quot[0] <= {{(wvcb_pkg::Q_W-1){1'b0}}, n_st[0][wvcb_pkg::WT_W]};
        for (int s = 1; s < wvcb_pkg::DIV_STAGES; s++) begin
            r_rem[s]  <= n_st[s][wvcb_pkg::WT_W-1:0];
            r_low[s]  <= r_low[s-1];
            r_dv[s]   <= r_dv[s-1];
            r_quot[s] <= {r_quot[s-1][wvcb_pkg::Q_W-2:0], n_st[s][wvcb_pkg::WT_W]};
        end
    end

    assign o_quot = r_quot[wvcb_pkg::DIV_STAGES-1];

endmodule

[src/weighted_variance_cell_bank_top.sv]
// Top level of the weighted variance cell bank: cell memory, update and variance pipelines.
//
//  channel  | handshake            | words
//  ---------+----------------------+---------------------------------------------
//  command  | start, busy          | func, cell_index, sample_value, sample_weight
//  result   | o_strobe (one cycle) | cell_mean_out, variance_estimate, empty_flag
//
// One word accepted per cycle while busy is low; results pass two 17-stage dividers.
// busy is high while an earlier word to the same cell has not yet been written back
// (read-modify-write window on the cell memory, from stage A until stage E writes back).
// After reset a clearing pass zeroes all 4096 cells of the memory, busy high throughout.
// Results cannot be held off; the pipeline never stalls.
`include "weighted_variance_cell_bank_top_macros.svh"

module weighted_variance_cell_bank_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_func,
    input  logic [wvcb_pkg::IDX_W-1:0] i_cell_index,
    input  logic [wvcb_pkg::VAL_W-1:0] i_sample_value,
    input  logic [wvcb_pkg::VAL_W-1:0] i_sample_weight,
    output logic                       o_strobe,
    output logic [wvcb_pkg::VAL_W-1:0] o_cell_mean_out,
    output logic [wvcb_pkg::VAL_W-1:0] o_variance_estimate,
    output logic                       o_empty_flag
);

    localparam int VW = wvcb_pkg::VAL_W;
    localparam int WW = wvcb_pkg::WT_W;
    localparam int SW = wvcb_pkg::SP_W;
    localparam int AW = wvcb_pkg::CELL_AW;
    localparam int NS = wvcb_pkg::DIV_STAGES;

    wvcb_pkg::t_entry   r_mem [wvcb_pkg::CELL_COUNT];
    wvcb_pkg::t_entry   r_rd;
    wvcb_pkg::t_stage_a r_a;
    wvcb_pkg::t_stage_b r_b, n_b;
    wvcb_pkg::t_stage_b r_d [NS];
    wvcb_pkg::t_stage_e r_e, n_e;
    wvcb_pkg::t_stage_f r_f, n_f;
    wvcb_pkg::t_stage_g r_g [NS];
    wvcb_pkg::t_stage_g n_g;

    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] w_idx;
    logic          w_accept;
    logic          w_hazard;

    logic [wvcb_pkg::Q_W-1:0] w_q1, w_q2;
    logic [WW-1:0]            w_rem2;
    logic [VW-1:0]            w_v_in, w_w_in;

    assign w_idx    = i_cell_index[AW-1:0];
    assign w_accept = start && !busy;
    assign busy     = r_clearing || w_hazard;
    assign w_v_in   = (i_sample_value  > wvcb_pkg::ONE_Q16) ? wvcb_pkg::ONE_Q16 : i_sample_value;
    assign w_w_in   = (i_sample_weight > wvcb_pkg::ONE_Q16) ? wvcb_pkg::ONE_Q16
                                                             : i_sample_weight;

    // words not yet written back to the same cell
    always_comb begin
        w_hazard = (r_a.valid && r_a.addr == w_idx) || (r_b.valid && r_b.addr == w_idx) ||
                   (r_e.valid && r_e.addr == w_idx);
        for (int s = 0; s < NS; s++) begin
            if (r_d[s].valid && r_d[s].addr == w_idx) begin
                w_hazard = 1'b1;
            end
        end
    end

    // stage A: memory data in, weight add, first product
    always_comb begin
        logic [WW:0]   wsum;
        logic [WW-1:0] wsat;
        logic          acc;
        logic          clr;
        logic [VW-1:0] m0;
        wsum = {1'b0, r_rd.wt} + (WW+1)'(r_a.w);
        wsat = wsum[WW] ? {WW{1'b1}} : wsum[WW-1:0];
        acc  = (r_a.func == wvcb_pkg::FUNC_ACC);
        clr  = (r_a.func == wvcb_pkg::FUNC_CLEAR);
        m0   = clr ? '0 : r_rd.m;
        n_b.valid = r_a.valid;
        n_b.addr  = r_a.addr;
        n_b.v     = r_a.v;
        n_b.m     = m0;
        n_b.wt    = clr ? '0 : (acc ? wsat : r_rd.wt);
        n_b.s     = clr ? '0 : r_rd.s;
        n_b.upd   = acc && (wsat != '0);
        n_b.dir   = (r_a.v >= m0);
        n_b.d_old = n_b.dir ? (r_a.v - m0) : (m0 - r_a.v);
        n_b.p     = r_a.w * n_b.d_old;
    end

    wvcb_div u_div_mean (
        .i_clk  (i_clk),
        .i_rem  (WW'(r_b.p[wvcb_pkg::PROD1_W-1:VW])),
        .i_low  (r_b.p[VW-1:0]),
        .i_div  (r_b.wt),
        .o_quot (w_q1)
    );

    // stage C: new mean, second product
    always_comb begin
        wvcb_pkg::t_stage_b d;
        logic [VW-1:0] delta;
        logic [VW-1:0] m_new;
        logic [VW-1:0] d_new;
        d     = r_d[NS-1];
        delta = (w_q1 > d.d_old) ? d.d_old : w_q1;
        m_new = d.upd ? (d.dir ? d.m + delta : d.m - delta) : d.m;
        d_new = (d.v >= m_new) ? (d.v - m_new) : (m_new - d.v);
        n_e.valid = d.valid;
        n_e.upd   = d.upd;
        n_e.addr  = d.addr;
        n_e.m     = m_new;
        n_e.wt    = d.wt;
        n_e.s     = d.s;
        n_e.prod  = d.p * d_new;
    end

    // stage E: spread sum, write back
    always_comb begin
        logic [wvcb_pkg::INC_W-1:0] inc;
        logic [SW:0]                ssum;
        inc  = r_e.upd ? r_e.prod[wvcb_pkg::PROD2_W-1:16] : '0;
        ssum = {1'b0, r_e.s} + (SW+1)'(inc);
        n_f.valid = r_e.valid;
        n_f.m     = r_e.m;
        n_f.wt    = r_e.wt;
        n_f.s     = ssum[SW] ? {SW{1'b1}} : ssum[SW-1:0];
    end

    // stage F: variance divider input
    always_comb begin
        logic [WW-1:0] hi;
        hi        = WW'(r_f.s[SW-1:VW]);
        n_g.valid = r_f.valid;
        n_g.m     = r_f.m;
        n_g.empty = (r_f.wt == '0);
        n_g.ovf   = (hi >= r_f.wt);
        w_rem2    = n_g.ovf ? '0 : hi;
    end

    wvcb_div u_div_var (
        .i_clk  (i_clk),
        .i_rem  (w_rem2),
        .i_low  (r_f.s[VW-1:0]),
        .i_div  (r_f.wt),
        .o_quot (w_q2)
    );

    // cell memory
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (r_e.valid) begin
            r_mem[r_e.addr] <= '{m: n_f.m, wt: n_f.wt, s: n_f.s};
        end
        if (w_accept) begin
            r_rd <= r_mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(wvcb_pkg::CELL_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
            r_e <= '0;
            r_f <= '0;
            for (int s = 0; s < NS; s++) begin
                r_d[s] <= '0;
                r_g[s] <= '0;
            end
            o_strobe <= 1'b0;
        end else begin
            r_a.valid <= w_accept;
            r_a.func  <= i_func;
            r_a.addr  <= w_idx;
            r_a.v     <= w_v_in;
            r_a.w     <= w_w_in;
            r_b       <= n_b;
            r_d[0]    <= r_b;
            r_e       <= n_e;
            r_f       <= n_f;
            r_g[0]    <= n_g;
            for (int s = 1; s < NS; s++) begin
                r_d[s] <= r_d[s-1];
                r_g[s] <= r_g[s-1];
            end
            o_strobe <= r_g[NS-1].valid;
        end
        o_cell_mean_out <= r_g[NS-1].m;
        o_empty_flag    <= r_g[NS-1].empty;
        if (r_g[NS-1].empty) begin
            o_variance_estimate <= '0;
        end else if (r_g[NS-1].ovf || w_q2 > wvcb_pkg::ONE_Q16) begin
            o_variance_estimate <= wvcb_pkg::ONE_Q16;
        end else begin
            o_variance_estimate <= w_q2;
        end
    end

    `WVCB_ASSERT_LAT(a_latency, w_accept, o_strobe)
    `WVCB_ASSERT_IMP(a_empty_zero, o_strobe && o_empty_flag, ~|{o_variance_estimate, o_cell_mean_out})
    `WVCB_ASSERT_IMP(a_clear_quiet, r_clearing, !r_a.valid && !r_e.valid)

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the weighted variance cell bank top level.
`timescale 1ns / 100ps

module tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = wvcb_pkg::LATENCY + 20;

    typedef struct packed {
        logic [1:0]                 func;
        logic [wvcb_pkg::IDX_W-1:0] addr;
        logic [wvcb_pkg::VAL_W-1:0] v;
        logic [wvcb_pkg::VAL_W-1:0] w;
    } t_cmd;

    typedef struct packed {
        logic [wvcb_pkg::VAL_W-1:0] mean;
        logic [wvcb_pkg::VAL_W-1:0] var_q;
        logic                       empty;
    } t_stats;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [1:0]                 i_func;
    logic [wvcb_pkg::IDX_W-1:0] i_cell_index;
    logic [wvcb_pkg::VAL_W-1:0] i_sample_value;
    logic [wvcb_pkg::VAL_W-1:0] i_sample_weight;
    logic                       o_strobe;
    logic [wvcb_pkg::VAL_W-1:0] o_cell_mean_out;
    logic [wvcb_pkg::VAL_W-1:0] o_variance_estimate;
    logic                       o_empty_flag;

    weighted_variance_cell_bank_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_func              (i_func),
        .i_cell_index        (i_cell_index),
        .i_sample_value      (i_sample_value),
        .i_sample_weight     (i_sample_weight),
        .o_strobe            (o_strobe),
        .o_cell_mean_out     (o_cell_mean_out),
        .o_variance_estimate (o_variance_estimate),
        .o_empty_flag        (o_empty_flag)
    );

    logic [wvcb_pkg::VAL_W-1:0] mdl_mean  [wvcb_pkg::CELL_COUNT];
    logic [wvcb_pkg::WT_W-1:0]  mdl_wt    [wvcb_pkg::CELL_COUNT];
    logic [wvcb_pkg::SP_W-1:0]  mdl_spread[wvcb_pkg::CELL_COUNT];

    t_cmd   cmd_queue[$];
    t_stats stats_due[$];
    t_cmd   cmd_cur;
    logic   cmd_taken;
    int     n_errors;
    int     n_words_in;
    int     n_words_out;
    int     n_acc;
    int     quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [wvcb_pkg::VAL_W-1:0] sat_one(input logic [63:0] x);
        return (x > 64'(wvcb_pkg::ONE_Q16)) ? wvcb_pkg::ONE_Q16 : x[wvcb_pkg::VAL_W-1:0];
    endfunction

    function automatic t_stats cell_update(input t_cmd c);
        t_stats      r;
        int          k;
        logic [16:0] v, w, m_old, m_new;
        logic [63:0] ws, d_old, d_new, delta, inc, s;
        k = int'(c.addr) % wvcb_pkg::CELL_COUNT;
        v = sat_one(64'(c.v));
        w = sat_one(64'(c.w));
        if (c.func == wvcb_pkg::FUNC_ACC) begin
            ws = 64'(mdl_wt[k]) + 64'(w);
            if (ws > 64'hFFFF_FFFF) ws = 64'hFFFF_FFFF;
            mdl_wt[k] = ws[wvcb_pkg::WT_W-1:0];
            if (ws != 0) begin
                m_old = mdl_mean[k];
                d_old = (v >= m_old) ? 64'(v - m_old) : 64'(m_old - v);
                delta = (64'(w) * d_old) / ws;
                if (delta > d_old) delta = d_old;
                m_new = (v >= m_old) ? m_old + delta[16:0] : m_old - delta[16:0];
                mdl_mean[k] = m_new;
                d_new = (v >= m_new) ? 64'(v - m_new) : 64'(m_new - v);
                inc = (64'(w) * d_old * d_new) >> 16;
                s = 64'(mdl_spread[k]) + inc;
                if (s > 64'hFF_FFFF_FFFF) s = 64'hFF_FFFF_FFFF;
                mdl_spread[k] = s[wvcb_pkg::SP_W-1:0];
            end
        end else if (c.func == wvcb_pkg::FUNC_CLEAR) begin
            mdl_mean[k]   = '0;
            mdl_wt[k]     = '0;
            mdl_spread[k] = '0;
        end
        r.mean = mdl_mean[k];
        if (mdl_wt[k] == 0) begin
            r.var_q = '0;
            r.empty = 1'b1;
        end else begin
            r.var_q = sat_one(64'(mdl_spread[k]) / 64'(mdl_wt[k]));
            r.empty = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
                 n_words_out);
    endtask

    task automatic push_cmd(input logic [1:0] f, input int c, input int v, input int w);
        t_cmd x;
        x.func = f;
        x.addr = c[wvcb_pkg::IDX_W-1:0];
        x.v    = v[wvcb_pkg::VAL_W-1:0];
        x.w    = w[wvcb_pkg::VAL_W-1:0];
        cmd_queue.insert(cmd_queue.size(), x);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || cmd_taken)) begin
            cmd_taken = 1'b0;
            if (cmd_queue.size() > 0 &&
                (n_words_in inside {[300:600]} || $urandom_range(99) >= 16)) begin
                cmd_cur = cmd_queue.pop_front();
                start           <= 1'b1;
                i_func          <= cmd_cur.func;
                i_cell_index    <= cmd_cur.addr;
                i_sample_value  <= cmd_cur.v;
                i_sample_weight <= cmd_cur.w;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // acceptance and result monitor
    always @(posedge i_clk) begin
        t_stats e;
        quiet_cycles++;
        if (i_rst_n && start && !busy && !cmd_taken) begin
            cmd_taken = 1'b1;
            stats_due.insert(stats_due.size(), cell_update(cmd_cur));
            n_words_in++;
            if (cmd_cur.func == wvcb_pkg::FUNC_ACC) n_acc++;
            quiet_cycles = 0;
        end
        if (i_rst_n && o_strobe) begin
            quiet_cycles = 0;
            n_words_out++;
            if (stats_due.size() == 0) begin
                report_mismatch("unexpected result", 32'(n_words_out), 32'(0));
            end else begin
                e = stats_due.pop_front();
                if (o_cell_mean_out !== e.mean)
                    report_mismatch("mean", 32'(o_cell_mean_out), 32'(e.mean));
                if (o_variance_estimate !== e.var_q)
                    report_mismatch("variance", 32'(o_variance_estimate), 32'(e.var_q));
                if (o_empty_flag !== e.empty)
                    report_mismatch("empty", 32'(o_empty_flag), 32'(e.empty));
            end
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", quiet_cycles);
            $display("weighted_variance_cell_bank_top regression: fail");
            $finish;
        end
    end

    initial begin
        int hot[8];
        int r, cidx, v, w;
        logic [1:0] f;
        for (int i = 0; i < wvcb_pkg::CELL_COUNT; i++) begin
            mdl_mean[i]   = '0;
            mdl_wt[i]     = '0;
            mdl_spread[i] = '0;
        end
        n_errors = 0; n_words_in = 0; n_words_out = 0; n_acc = 0;
        quiet_cycles = 0; cmd_taken = 1'b0;
        cmd_cur = '0;
        i_rst_n = 1'b0; start = 1'b0; i_func = '0; i_cell_index = '0;
        i_sample_value = '0; i_sample_weight = '0;

        // directed words
        push_cmd(wvcb_pkg::FUNC_READ, 0, 0, 0);
        push_cmd(wvcb_pkg::FUNC_ACC, 5, 40000, 0);
        push_cmd(wvcb_pkg::FUNC_READ, 5, 0, 0);
        push_cmd(wvcb_pkg::FUNC_ACC, 4095, 65536, 65536);
        push_cmd(wvcb_pkg::FUNC_ACC, 4095, 131071, 131071);
        push_cmd(wvcb_pkg::FUNC_ACC, 4095, 0, 65536);
        push_cmd(wvcb_pkg::FUNC_ACC, 4095, 0, 1);
        push_cmd(wvcb_pkg::FUNC_READ_ALT, 4095, 131071, 131071);
        push_cmd(wvcb_pkg::FUNC_CLEAR, 4095, 12345, 777);
        push_cmd(wvcb_pkg::FUNC_READ, 4095, 0, 0);
        push_cmd(wvcb_pkg::FUNC_ACC, 1, 0, 65536);
        push_cmd(wvcb_pkg::FUNC_ACC, 1, 65536, 65536);
        push_cmd(wvcb_pkg::FUNC_ACC, 1, 0, 65536);
        push_cmd(wvcb_pkg::FUNC_ACC, 1, 65536, 32768);
        push_cmd(wvcb_pkg::FUNC_ACC, 1, 98304, 100000);
        push_cmd(wvcb_pkg::FUNC_ACC, 2, 30000, 1);
        push_cmd(wvcb_pkg::FUNC_ACC, 2, 65535, 65535);
        push_cmd(wvcb_pkg::FUNC_ACC, 2048, 0, 0);
        push_cmd(wvcb_pkg::FUNC_ACC, 2048, 21845, 43690);
        push_cmd(wvcb_pkg::FUNC_CLEAR, 0, 0, 0);
        push_cmd(wvcb_pkg::FUNC_READ_ALT, 1, 0, 0);

        // random words, mostly accumulates into a few busy cells
        for (int i = 0; i < 8; i++) hot[i] = $urandom_range(4095);
        for (int i = 0; i < 1000; i++) begin
            r = $urandom_range(99);
            if (r < 75) f = wvcb_pkg::FUNC_ACC;
            else if (r < 88) f = wvcb_pkg::FUNC_READ;
            else if (r < 94) f = wvcb_pkg::FUNC_CLEAR;
            else f = wvcb_pkg::FUNC_READ_ALT;
            cidx = ($urandom_range(3) == 0) ? $urandom_range(4095) : hot[$urandom_range(7)];
            v = ($urandom_range(9) == 0) ? $urandom_range(131071) : $urandom_range(65536);
            r = $urandom_range(19);
            if (r == 0) w = 0;
            else if (r == 1) w = $urandom_range(131071);
            else if (r < 4) w = $urandom_range(15);
            else w = $urandom_range(65536);
            push_cmd(f, cidx, v, w);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (cmd_queue.size() == 0);
        @(posedge i_clk);
        while (start && !cmd_taken) @(posedge i_clk);
        while (stats_due.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d words (%0d accumulates), %0d results checked, %0d errors",
                 n_words_in, n_acc, n_words_out, n_errors);
        if (n_errors == 0 && stats_due.size() == 0)
            $display("weighted_variance_cell_bank_top regression: pass");
        else
            $display("weighted_variance_cell_bank_top regression: fail");
        $finish;
    end
endmodule

[weighted_variance_cell_bank_top.f]
+incdir+src
src/wvcb_pkg.sv
src/wvcb_div.sv
src/weighted_variance_cell_bank_top.sv
tb/sv/tb.sv
